>>> hdl/chacha20_key_erasure_rng_macros.svh
// Assertion macros for the key-erasure generator.
// Clock and reset are taken as clock and reset of the including module.
`ifndef CHACHA20_KEY_ERASURE_RNG_MACROS_SVH
`define CHACHA20_KEY_ERASURE_RNG_MACROS_SVH

// Property that must hold at every edge out of reset.
`define CKERNG_ASSERT_NOW(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Property that must hold in the cycle after a trigger.
`define CKERNG_ASSERT_NEXT(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) else $error(msg);

`endif

>>> hdl/ckerng_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and ChaCha20 helper functions of the generator.
// No dependencies.
package ckerng_pkg;

   localparam int POOL_BYTES     = 512;
   localparam int MAX_READ_BYTES = 64;
   localparam int KEY_BYTES      = 32;
   localparam int BLOCKS         = (POOL_BYTES + 63) / 64;
   localparam int WORDS          = BLOCKS * 8;
   localparam int WORD_AW        = $clog2(WORDS);
   localparam int BLK_W          = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int IDX_W          = $clog2(POOL_BYTES) + 1;
   localparam int CNT_W          = 7;
   localparam int CSR_NUM        = 4;
   localparam int CSR_AW         = 2;
   localparam int CSR_DW         = 64;
   localparam int ROUNDS         = 10;

   typedef enum logic [1:0] {
      ROT_16 = 2'd0,
      ROT_12 = 2'd1,
      ROT_8  = 2'd2,
      ROT_7  = 2'd3
   } rot_type;

   typedef enum logic {
      FUNC_RESEED = 1'b0,
      FUNC_READ   = 1'b1
   } func_type;

   // State word index for one position (a, b, c, d) of quarter round qr.
   // Quarter rounds 0..3 are columns, 4..7 diagonals.
   function automatic logic [3:0] qr_index(input logic [2:0] qr, input logic [1:0] pos);
      logic [1:0] col;
      col = qr[1:0] + (qr[2] ? pos : 2'd0);
      return {pos, col};
   endfunction

   // Initial block state word i for a given key and block counter.
   function automatic logic [31:0] block_input(input logic [255:0] key,
                                               input logic [BLK_W-1:0] blk,
                                               input logic [3:0] i);
      logic [31:0] w;
      case (i)
         4'd0: w = 32'h61707865;
         4'd1: w = 32'h3320646e;
         4'd2: w = 32'h79622d32;
         4'd3: w = 32'h6b206574;
         4'd12: w = 32'(blk);
         4'd13, 4'd14, 4'd15: w = 32'd0;
         default: w = key[(32'(i) - 32'd4) * 32 +: 32];
      endcase
      return w;
   endfunction

endpackage

>>> hdl/ckerng_if.sv
`timescale 1ns / 1ps
// Request and result channel interfaces (valid/ready).
// Depends on ckerng_pkg.
interface ckerng_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [ckerng_pkg::CNT_W-1:0]  byte_count;
   modport source (output valid, output func, output byte_count, input ready);
   modport sink   (input valid, input func, input byte_count, output ready);
endinterface

interface ckerng_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] random_byte;
   logic       last_byte;
   modport source (output valid, output random_byte, output last_byte, input ready);
   modport sink   (input valid, input random_byte, input last_byte, output ready);
endinterface

>>> hdl/ckerng_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ckerng_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> hdl/ckerng_arx.sv
`timescale 1ns / 1ps
// Shared add-xor-rotate unit: one quarter-round step of ChaCha20.
// Depends on ckerng_pkg.
module ckerng_arx (
   input  logic                        [31:0] a,
   input  logic                        [31:0] b,
   input  logic                        [31:0] d,
   input  ckerng_pkg::rot_type                rot,
   output logic                        [31:0] sum,
   output logic                        [31:0] mix
);
   logic [31:0] t;

   always_comb begin
      sum = a + b;
      t   = d ^ sum;
      case (rot)
         ckerng_pkg::ROT_16: mix = {t[15:0], t[31:16]};
         ckerng_pkg::ROT_12: mix = {t[19:0], t[31:20]};
         ckerng_pkg::ROT_8:  mix = {t[23:0], t[31:24]};
         ckerng_pkg::ROT_7:  mix = {t[24:0], t[31:25]};
         default:            mix = t;
      endcase
   end
endmodule

>>> hdl/chacha20_key_erasure_rng.sv
`timescale 1ns / 1ps
// Read: per byte RD_ISSUE (RAM read), RD_DATA (output load), RD_WAIT (handoff, held until
// rsp.ready), plus a refill when the pool is spent. Refill: key fetch in KEY_FETCH, then per
// block INIT, 320 ARX steps (one per cycle on the shared unit) and 8 pool writes, for 8 blocks.
// Reseed takes a refill without fetch. Reset (synchronous, active high) clears seeds and pool valid
// bits (pool reads as zero), sets the read index to 32. Not ready while an item is in progress.
`include "chacha20_key_erasure_rng_macros.svh"
module chacha20_key_erasure_rng (
   input  logic                             clock,
   input  logic                             reset,
   ckerng_req_if.sink                       req,
   ckerng_rsp_if.source                     rsp,
   input  logic                             csr_we,
   input  logic [ckerng_pkg::CSR_AW-1:0]    csr_index,
   input  logic [ckerng_pkg::CSR_DW-1:0]    csr_wdata
);
   localparam int AW = ckerng_pkg::WORD_AW;
   localparam int BW = ckerng_pkg::BLK_W;
   localparam int IW = ckerng_pkg::IDX_W;
   localparam int CW = ckerng_pkg::CNT_W;

   typedef enum logic [2:0] {
      IDLE, KEY_FETCH, INIT, ROUND, FEED, RD_ISSUE, RD_DATA, RD_WAIT
   } state_type;

   state_type        state_ff, state_in;
   logic [255:0]     seed_ff, seed_in;
   logic [255:0]     key_ff, key_in;
   logic [31:0]      x_ff [16];
   logic [31:0]      x_in [16];
   logic [BW-1:0]    blk_ff, blk_in;
   logic [3:0]       rnd_ff, rnd_in;
   logic [2:0]       qr_ff, qr_in;
   logic [1:0]       stp_ff, stp_in;
   logic [2:0]       k_ff, k_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    rem_ff, rem_in;
   logic             ret_read_ff, ret_read_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_last_ff, out_last_in;
   logic [ckerng_pkg::WORDS-1:0] valid_ff, valid_in;
   logic             rvalid_ff, rvalid_in;

   logic [AW-1:0]    raddr, waddr;
   logic             we;
   logic [63:0]      wdata, rdata, word;
   logic [3:0]       ia, ib, id, i_lo, i_hi;
   logic [31:0]      sum, mix;
   ckerng_pkg::rot_type rot;
   logic [CW-1:0]    cnt;

   ckerng_ram #(.WIDTH(64), .DEPTH(ckerng_pkg::WORDS)) u_pool (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   ckerng_arx u_arx (
      .a   (x_ff[ia]),
      .b   (x_ff[ib]),
      .d   (x_ff[id]),
      .rot (rot),
      .sum (sum),
      .mix (mix)
   );

   // never-written words read as the reset value, zero
   assign word = rvalid_ff ? rdata : 64'd0;

   always_comb begin
      // odd steps work on (c, d, b), even steps on (a, b, d)
      ia   = ckerng_pkg::qr_index(qr_ff, stp_ff[0] ? 2'd2 : 2'd0);
      ib   = ckerng_pkg::qr_index(qr_ff, stp_ff[0] ? 2'd3 : 2'd1);
      id   = ckerng_pkg::qr_index(qr_ff, stp_ff[0] ? 2'd1 : 2'd3);
      rot  = ckerng_pkg::rot_type'(stp_ff);
      i_lo = {k_ff, 1'b0};
      i_hi = {k_ff, 1'b1};
      cnt  = (req.byte_count > CW'(ckerng_pkg::MAX_READ_BYTES)) ?
             CW'(ckerng_pkg::MAX_READ_BYTES) : req.byte_count;

      we    = (state_ff == FEED);
      waddr = {blk_ff, k_ff};
      wdata = {x_ff[i_hi] + ckerng_pkg::block_input(key_ff, blk_ff, i_hi),
               x_ff[i_lo] + ckerng_pkg::block_input(key_ff, blk_ff, i_lo)};
      raddr = (state_ff == KEY_FETCH) ? AW'(k_ff) : idx_ff[IW-2:3];

      state_in     = state_ff;
      seed_in      = seed_ff;
      key_in       = key_ff;
      x_in         = x_ff;
      blk_in       = blk_ff;
      rnd_in       = rnd_ff;
      qr_in        = qr_ff;
      stp_in       = stp_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      ret_read_in  = ret_read_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      valid_in     = valid_ff;
      rvalid_in    = valid_ff[raddr];

      if (csr_we) begin
         seed_in[64*csr_index +: 64] = csr_wdata;
      end

      case (state_ff)
         IDLE: begin
            if (req.valid) begin
               if (req.func == ckerng_pkg::FUNC_RESEED) begin
                  key_in      = seed_ff;
                  blk_in      = '0;
                  ret_read_in = 1'b0;
                  state_in    = INIT;
               end else if (cnt != '0) begin
                  rem_in   = cnt;
                  state_in = RD_ISSUE;
               end
            end
         end
         KEY_FETCH: begin
            // k_ff is the address in flight; word holds the registered data of address k_ff - 1
            if (k_ff != 3'd0) begin
               key_in[64*(k_ff - 3'd1) +: 64] = word;
            end
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd4) begin
               k_in     = '0;
               blk_in   = '0;
               state_in = INIT;
            end
         end
         INIT: begin
            for (int i = 0; i < 16; i++) begin
               x_in[i] = ckerng_pkg::block_input(key_ff, blk_ff, 4'(i));
            end
            rnd_in   = '0;
            qr_in    = '0;
            stp_in   = '0;
            state_in = ROUND;
         end
         ROUND: begin
            x_in[ia] = sum;
            x_in[id] = mix;
            stp_in   = stp_ff + 2'd1;
            if (stp_ff == 2'd3) begin
               qr_in = qr_ff + 3'd1;
               if (qr_ff == 3'd7) begin
                  rnd_in = rnd_ff + 4'd1;
                  if (rnd_ff == 4'(ckerng_pkg::ROUNDS - 1)) begin
                     k_in     = '0;
                     state_in = FEED;
                  end
               end
            end
         end
         FEED: begin
            valid_in[waddr] = 1'b1;
            k_in            = k_ff + 3'd1;
            if (k_ff == 3'd7) begin
               if (blk_ff == BW'(ckerng_pkg::BLOCKS - 1)) begin
                  idx_in   = IW'(ckerng_pkg::KEY_BYTES);
                  state_in = ret_read_ff ? RD_ISSUE : IDLE;
               end else begin
                  blk_in   = blk_ff + BW'(1);
                  state_in = INIT;
               end
            end
         end
         RD_ISSUE: begin
            if (idx_ff == IW'(ckerng_pkg::POOL_BYTES)) begin
               ret_read_in = 1'b1;
               k_in        = '0;
               state_in    = KEY_FETCH;
            end else begin
               state_in = RD_DATA;
            end
         end
         RD_DATA: begin
            out_byte_in  = word[8*idx_ff[2:0] +: 8];
            out_last_in  = (rem_ff == CW'(1));
            out_valid_in = 1'b1;
            idx_in       = idx_ff + IW'(1);
            rem_in       = rem_ff - CW'(1);
            state_in     = RD_WAIT;
         end
         RD_WAIT: begin
            if (rsp.ready) begin
               out_valid_in = 1'b0;
               state_in     = (rem_ff == '0) ? IDLE : RD_ISSUE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         seed_ff      <= '0;
         valid_ff     <= '0;
         idx_ff       <= IW'(ckerng_pkg::KEY_BYTES);
         out_valid_ff <= 1'b0;
         ret_read_ff  <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         valid_ff     <= valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
         ret_read_ff  <= ret_read_in;
         k_ff         <= k_in;
      end
      key_ff      <= key_in;
      x_ff        <= x_in;
      blk_ff      <= blk_in;
      rnd_ff      <= rnd_in;
      qr_ff       <= qr_in;
      stp_ff      <= stp_in;
      rem_ff      <= rem_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      rvalid_ff   <= rvalid_in;
   end

   assign req.ready       = (state_ff == IDLE);
   assign rsp.valid       = out_valid_ff;
   assign rsp.random_byte = out_byte_ff;
   assign rsp.last_byte   = out_last_ff;

   `CKERNG_ASSERT_NOW(a_rsp_in_wait, !out_valid_ff || state_ff == RD_WAIT, "result outside wait")
   `CKERNG_ASSERT_NOW(a_idx_range, idx_ff <= IW'(ckerng_pkg::POOL_BYTES), "read index overrun")
   `CKERNG_ASSERT_NOW(a_we_feed, !we || state_ff == FEED, "pool write outside refill")
   `CKERNG_ASSERT_NEXT(a_load_out, state_ff == RD_DATA, out_valid_ff, "byte not presented")
endmodule

>>> tb/tb_chacha20_key_erasure_rng.sv
`timescale 1ns / 1ps
// Self-checking testbench for chacha20_key_erasure_rng: drives reseed and read requests,
// predicts every served byte with its own ChaCha20 pool model. Depends on ckerng_pkg, ckerng_if.
module tb_chacha20_key_erasure_rng;

   localparam int  SETTLE_CYCLES = 3000;   // longer than one refill
   localparam int  LONG_HOLD     = 600;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct packed {
      ckerng_pkg::func_type            func;
      logic [ckerng_pkg::CNT_W-1:0]    count;
   } rng_request_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } rng_byte_type;

   logic clock;
   logic reset;
   logic                          csr_we;
   logic [ckerng_pkg::CSR_AW-1:0] csr_index;
   logic [ckerng_pkg::CSR_DW-1:0] csr_wdata;

   ckerng_req_if req_ch();
   ckerng_rsp_if rsp_ch();

   chacha20_key_erasure_rng DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rng_request_type request_queue[$];
   rng_byte_type    pending_bytes[$];

   // predictor state
   logic [63:0] seed_shadow[ckerng_pkg::CSR_NUM];
   logic [63:0] pool_words[ckerng_pkg::WORDS];
   int          pool_pos;
   logic [31:0] mix[16];

   int     error_count;
   longint cycle_count;
   logic   taken;
   int     burst_left;
   int     gap_left;
   int     hold_left;
   logic   hold_trigger;
   int     stall_phase;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   task automatic quarter_round(input int a, input int b, input int c, input int d);
      mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
      mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
      mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
      mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
   endtask

   // Rekey from the first 32 pool bytes and overwrite the pool with keystream.
   task automatic refill_pool();
      logic [31:0] key[8];
      logic [31:0] init[16];
      for (int k = 0; k < 8; k++)
         key[k] = pool_words[k >> 1][32 * (k & 1) +: 32];
      for (int blk = 0; blk < ckerng_pkg::BLOCKS; blk++) begin
         init[0] = 32'h61707865; init[1] = 32'h3320646e;
         init[2] = 32'h79622d32; init[3] = 32'h6b206574;
         for (int k = 0; k < 8; k++)
            init[4 + k] = key[k];
         init[12] = 32'(blk); init[13] = '0; init[14] = '0; init[15] = '0;
         for (int k = 0; k < 16; k++)
            mix[k] = init[k];
         for (int r = 0; r < ckerng_pkg::ROUNDS; r++) begin
            quarter_round(0, 4, 8, 12);
            quarter_round(1, 5, 9, 13);
            quarter_round(2, 6, 10, 14);
            quarter_round(3, 7, 11, 15);
            quarter_round(0, 5, 10, 15);
            quarter_round(1, 6, 11, 12);
            quarter_round(2, 7, 8, 13);
            quarter_round(3, 4, 9, 14);
         end
         for (int k = 0; k < 8; k++)
            pool_words[blk * 8 + k] = {mix[2*k+1] + init[2*k+1], mix[2*k] + init[2*k]};
      end
      pool_pos = ckerng_pkg::KEY_BYTES;
   endtask

   task automatic predict_request(input rng_request_type item);
      int n;
      rng_byte_type b;
      if (item.func == ckerng_pkg::FUNC_RESEED) begin
         for (int k = 0; k < ckerng_pkg::CSR_NUM; k++)
            pool_words[k] = seed_shadow[k];
         refill_pool();
      end else begin
         n = (int'(item.count) > ckerng_pkg::MAX_READ_BYTES) ?
             ckerng_pkg::MAX_READ_BYTES : int'(item.count);
         for (int i = 0; i < n; i++) begin
            if (pool_pos >= ckerng_pkg::POOL_BYTES)
               refill_pool();
            b.value = pool_words[pool_pos >> 3][8 * (pool_pos & 7) +: 8];
            b.last  = (i + 1 == n);
            pending_bytes.push_back(b);
            pool_pos++;
         end
      end
   endtask

   // sender: accept at the rising edge
   always @(posedge clock) begin
      taken <= 1'b0;
      if (!reset && req_ch.valid && req_ch.ready) begin
         predict_request(request_queue.pop_front());
         taken <= 1'b1;
      end
   end

   // sender: drive at the falling edge, in bursts with gaps
   always @(negedge clock) begin
      if (!reset && !(req_ch.valid && !taken)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_ch.valid <= 1'b0;
         end else if (request_queue.size() > 0) begin
            req_ch.valid      <= 1'b1;
            req_ch.func       <= request_queue[0].func;
            req_ch.byte_count <= request_queue[0].count;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 12);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_trigger && hold_left == 0) begin
         hold_left <= LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 1) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (hold_left == 1)
            hold_left <= -1;
         stall_phase <= (stall_phase + 1) % 200;
         if (stall_phase < 60)
            rsp_ch.ready <= 1'b1;
         else if (stall_phase < 150)
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         else
            rsp_ch.ready <= ($urandom_range(0, 1) == 0);
      end
   end

   // result checker
   always @(posedge clock) begin
      rng_byte_type exp_b;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_bytes.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("ERROR: unexpected byte %02h last %0b", rsp_ch.random_byte,
                        rsp_ch.last_byte);
         end else begin
            exp_b = pending_bytes.pop_front();
            if (rsp_ch.random_byte !== exp_b.value || rsp_ch.last_byte !== exp_b.last) begin
               error_count++;
               if (error_count <= 10)
                  $display("ERROR: byte exp %02h/%0b got %02h/%0b", exp_b.value, exp_b.last,
                           rsp_ch.random_byte, rsp_ch.last_byte);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_seed(input int idx, input logic [63:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = ckerng_pkg::CSR_AW'(idx);
      csr_wdata = data;
      seed_shadow[idx] = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic push_request(input ckerng_pkg::func_type f, input int cnt);
      rng_request_type item;
      item.func  = f;
      item.count = ckerng_pkg::CNT_W'(cnt);
      request_queue.push_back(item);
   endtask

   task automatic wait_idle();
      while (request_queue.size() != 0 || pending_bytes.size() != 0 || req_ch.valid)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_random(input int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 8)
            push_request(ckerng_pkg::FUNC_RESEED, $urandom_range(0, 127));
         else if (r < 13)
            push_request(ckerng_pkg::FUNC_READ, $urandom_range(0, 127));
         else if (r < 60)
            push_request(ckerng_pkg::FUNC_READ, $urandom_range(1, 8));
         else
            push_request(ckerng_pkg::FUNC_READ, $urandom_range(1, ckerng_pkg::MAX_READ_BYTES));
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      req_ch.valid = 1'b0; req_ch.func = ckerng_pkg::FUNC_READ; req_ch.byte_count = '0;
      rsp_ch.ready = 1'b0;
      error_count = 0; cycle_count = 0; taken = 1'b0;
      burst_left = 0; gap_left = 0; hold_left = 0; hold_trigger = 1'b0; stall_phase = 0;
      for (int k = 0; k < ckerng_pkg::CSR_NUM; k++)
         seed_shadow[k] = '0;
      for (int k = 0; k < ckerng_pkg::WORDS; k++)
         pool_words[k] = '0;
      pool_pos = ckerng_pkg::KEY_BYTES;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reads before any reseed: zero pool, then a refill keyed with zeros
      push_request(ckerng_pkg::FUNC_READ, 1);
      push_request(ckerng_pkg::FUNC_READ, 0);
      push_request(ckerng_pkg::FUNC_READ, 127);
      push_request(ckerng_pkg::FUNC_READ, 65);
      for (int i = 0; i < 7; i++)
         push_request(ckerng_pkg::FUNC_READ, ckerng_pkg::MAX_READ_BYTES);
      push_request(ckerng_pkg::FUNC_READ, 3);
      push_request(ckerng_pkg::FUNC_READ, 2);
      push_request(ckerng_pkg::FUNC_RESEED, 127);
      push_request(ckerng_pkg::FUNC_READ, 42);
      wait_idle();

      // all-ones seed at the other extreme
      for (int k = 0; k < ckerng_pkg::CSR_NUM; k++)
         write_seed(k, '1);
      push_request(ckerng_pkg::FUNC_RESEED, 0);
      push_request(ckerng_pkg::FUNC_READ, 85);
      push_request(ckerng_pkg::FUNC_READ, 1);
      push_random(120);
      wait_idle();

      // random seed; hold the result side off while requests keep coming
      for (int k = 0; k < ckerng_pkg::CSR_NUM; k++)
         write_seed(k, {$urandom, $urandom});
      push_request(ckerng_pkg::FUNC_RESEED, 1);
      push_random(130);
      repeat (50) @(posedge clock);
      hold_trigger = 1'b1;
      wait_idle();

      for (int k = 0; k < ckerng_pkg::CSR_NUM; k++)
         write_seed(k, (k % 2 == 0) ? 64'h0 : {$urandom, $urandom});
      push_random(120);
      wait_idle();

      for (int k = 0; k < ckerng_pkg::CSR_NUM; k++)
         write_seed(k, {$urandom, $urandom});
      push_request(ckerng_pkg::FUNC_RESEED, 64);
      push_random(110);
      wait_idle();

      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
